// ===== hdl/stereo_min_max_column_envelope_unit_macros.svh =====
// Assertion macros shared by the stereo envelope checker
`ifndef STEREO_MIN_MAX_COLUMN_ENVELOPE_UNIT_MACROS_SVH
`define STEREO_MIN_MAX_COLUMN_ENVELOPE_UNIT_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define SMMCE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("smmce: property violated");

// next-cycle implication, clocked on i_clk, off during reset
`define SMMCE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("smmce: property violated");

`endif

// ===== hdl/smmce_pkg.sv =====
// Shared constants and types for the stereo min/max column envelope unit
package smmce_pkg;

    localparam int EDGE_MARGIN = 4;

    localparam int SAMPLE_W  = 16;
    localparam int COL_W     = 16;
    localparam int ROW_W     = 13;
    localparam int PPC_W     = 16;
    localparam int LANE_W    = 13;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam int SHIFT   = 15;
    localparam int HALF_W  = LANE_W - 1;
    localparam int MID_W   = HALF_W + 1;
    localparam int PROD_W  = SAMPLE_W + HALF_W + 1;
    localparam int V_W     = PROD_W + 2;
    localparam int RC_W    = V_W - 1 - SHIFT;
    localparam int NPEAK   = 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_PPC  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LANE = 1'b1;

    localparam logic [PPC_W-1:0]  PPC_RESET  = 16'd1024;
    localparam logic [LANE_W-1:0] LANE_RESET = 13'd256;

    // peak order: left high, left low, right high, right low
    localparam int PK_LHI = 0;
    localparam int PK_LLO = 1;
    localparam int PK_RHI = 2;
    localparam int PK_RLO = 3;

    typedef struct packed {
        logic [COL_W-1:0]                   column;
        logic [NPEAK-1:0][SAMPLE_W-1:0]     peak;
    } t_snap;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== hdl/stereo_min_max_column_envelope_unit.sv =====
// Stereo min/max column envelope unit: top level with configuration registers
//
// Takes one interleaved stereo sample (left, then right) per clock, unless
// o_stall is high, and folds it into per-channel peak max/min registers, so the
// input side sustains one sample per cycle while not stalled. When a column
// completes, its column number and four peaks go into a four-entry queue; the
// back end turns each entry into four clamped bar rows through a two-stage
// pipeline (scale multiply, then offset, shift and clamp) and holds the result
// in an output register. A completed column passes from the queue through the
// product register into the output register. The back end drains one column
// per cycle while the output is not stalled, so the input stalls only when the
// output is held off long enough to fill the queue. Configuration writes take
// effect on the next cycle and are meant for when the unit is idle.
module stereo_min_max_column_envelope_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [smmce_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [smmce_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                   i_valid,
    input  logic signed [smmce_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                                   o_stall,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [smmce_pkg::COL_W-1:0]            o_column,
    output logic [smmce_pkg::ROW_W-1:0]            o_left_top_row,
    output logic [smmce_pkg::ROW_W-1:0]            o_left_bottom_row,
    output logic [smmce_pkg::ROW_W-1:0]            o_right_top_row,
    output logic [smmce_pkg::ROW_W-1:0]            o_right_bottom_row
);

    logic [smmce_pkg::PPC_W-1:0]  r_ppc;
    logic [smmce_pkg::LANE_W-1:0] r_lane;
    logic                         w_push;
    logic                         w_pop;
    smmce_pkg::t_snap             w_snap;
    smmce_pkg::t_snap             w_head;
    smmce_pkg::t_qstat            w_qstat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppc  <= smmce_pkg::PPC_RESET;
            r_lane <= smmce_pkg::LANE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                smmce_pkg::CFG_PPC: begin
                    r_ppc <= i_cfg_data[smmce_pkg::PPC_W-1:0];
                end
                smmce_pkg::CFG_LANE: begin
                    r_lane <= i_cfg_data[smmce_pkg::LANE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    smmce_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_sample (i_sample),
        .o_stall  (o_stall),
        .i_ppc    (r_ppc),
        .i_qstat  (w_qstat),
        .o_push   (w_push),
        .o_snap   (w_snap)
    );

    smmce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_snap  (w_snap),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    smmce_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_lane             (r_lane),
        .i_head             (w_head),
        .i_qstat            (w_qstat),
        .o_pop              (w_pop),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_column           (o_column),
        .o_left_top_row     (o_left_top_row),
        .o_left_bottom_row  (o_left_bottom_row),
        .o_right_top_row    (o_right_top_row),
        .o_right_bottom_row (o_right_bottom_row)
    );

endmodule

// ===== hdl/smmce_front.sv =====
// Front end: sample intake, peak folding and column completion
module smmce_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [smmce_pkg::SAMPLE_W-1:0] i_sample,
    output logic                          o_stall,
    input  logic [smmce_pkg::PPC_W-1:0]   i_ppc,
    input  smmce_pkg::t_qstat             i_qstat,
    output logic                          o_push,
    output smmce_pkg::t_snap              o_snap
);

    logic signed [smmce_pkg::SAMPLE_W-1:0] r_lhi, r_llo, r_rhi, r_rlo;
    logic signed [smmce_pkg::SAMPLE_W-1:0] n_lhi, n_llo, n_rhi, n_rlo;
    logic [smmce_pkg::PPC_W-1:0]           r_pc, n_pc;
    logic [smmce_pkg::COL_W-1:0]           r_col, n_col;
    logic                                  r_phase, n_phase;
    logic                                  w_acc;
    logic                                  w_done;

    assign o_stall = i_qstat.full;
    assign w_acc   = i_valid && !i_qstat.full;

    always_comb begin
        n_lhi   = r_lhi;
        n_llo   = r_llo;
        n_rhi   = r_rhi;
        n_rlo   = r_rlo;
        n_pc    = r_pc;
        n_col   = r_col;
        n_phase = r_phase;
        w_done  = 1'b0;
        if (w_acc) begin
            if (!r_phase) begin
                if (i_sample > r_lhi) begin
                    n_lhi = i_sample;
                end else if (i_sample < r_llo) begin
                    n_llo = i_sample;
                end
                n_phase = 1'b1;
            end else begin
                if (i_sample > r_rhi) begin
                    n_rhi = i_sample;
                end else if (i_sample < r_rlo) begin
                    n_rlo = i_sample;
                end
                n_phase = 1'b0;
                n_pc    = r_pc + 1'b1;
            end
            w_done = (n_pc >= i_ppc);
        end
        o_snap.column                  = r_col;
        o_snap.peak[smmce_pkg::PK_LHI] = n_lhi;
        o_snap.peak[smmce_pkg::PK_LLO] = n_llo;
        o_snap.peak[smmce_pkg::PK_RHI] = n_rhi;
        o_snap.peak[smmce_pkg::PK_RLO] = n_rlo;
        if (w_done) begin
            n_lhi = '0;
            n_llo = '0;
            n_rhi = '0;
            n_rlo = '0;
            n_pc  = '0;
            n_col = r_col + 1'b1;
        end
    end

    assign o_push = w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lhi   <= '0;
            r_llo   <= '0;
            r_rhi   <= '0;
            r_rlo   <= '0;
            r_pc    <= '0;
            r_col   <= '0;
            r_phase <= 1'b0;
        end else begin
            r_lhi   <= n_lhi;
            r_llo   <= n_llo;
            r_rhi   <= n_rhi;
            r_rlo   <= n_rlo;
            r_pc    <= n_pc;
            r_col   <= n_col;
            r_phase <= n_phase;
        end
    end

endmodule

// ===== hdl/smmce_queue.sv =====
// Short queue of finished column snapshots between front and back end
module smmce_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  smmce_pkg::t_snap  i_snap,
    input  logic              i_pop,
    output smmce_pkg::t_snap  o_head,
    output smmce_pkg::t_qstat o_qstat
);

    smmce_pkg::t_snap               r_mem [smmce_pkg::QUEUE_DEPTH];
    logic [smmce_pkg::QPTR_W-1:0]   r_wp, r_rp;
    logic [smmce_pkg::QCNT_W-1:0]   r_cnt;
    logic                           w_push, w_pop;

    assign o_qstat.full  = (r_cnt == smmce_pkg::QCNT_W'(smmce_pkg::QUEUE_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign o_head        = r_mem[r_rp];

    assign w_push = i_push && !o_qstat.full;
    assign w_pop  = i_pop && !o_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_snap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/smmce_back.sv =====
// Back end: scale the four peaks, convert to clamped rows, hold the result
module smmce_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [smmce_pkg::LANE_W-1:0]    i_lane,
    input  smmce_pkg::t_snap                i_head,
    input  smmce_pkg::t_qstat               i_qstat,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [smmce_pkg::COL_W-1:0]     o_column,
    output logic [smmce_pkg::ROW_W-1:0]     o_left_top_row,
    output logic [smmce_pkg::ROW_W-1:0]     o_left_bottom_row,
    output logic [smmce_pkg::ROW_W-1:0]     o_right_top_row,
    output logic [smmce_pkg::ROW_W-1:0]     o_right_bottom_row
);

    logic                                   w_en;
    logic [smmce_pkg::HALF_W-1:0]           w_half;
    logic [smmce_pkg::MID_W-1:0]            w_mid;
    logic [smmce_pkg::RC_W-1:0]             w_span;
    logic [smmce_pkg::RC_W-1:0]             w_limit;
    logic [smmce_pkg::ROW_W-1:0]            w_row [smmce_pkg::NPEAK];

    logic                                   r_v1;
    logic [smmce_pkg::COL_W-1:0]            r_col1;
    logic signed [smmce_pkg::PROD_W-1:0]    r_prod [smmce_pkg::NPEAK];
    logic                                   r_ov;

    assign w_en    = !r_ov || !i_stall;
    assign o_pop   = w_en && !i_qstat.empty;
    assign o_valid = r_ov;

    assign w_half = i_lane[smmce_pkg::LANE_W-1:1];
    assign w_mid  = smmce_pkg::MID_W'(w_half) + smmce_pkg::MID_W'(smmce_pkg::EDGE_MARGIN);
    assign w_span = smmce_pkg::RC_W'(i_lane) + smmce_pkg::RC_W'(2 * smmce_pkg::EDGE_MARGIN);

    always_comb begin
        if (w_span == '0) begin
            w_limit = '0;
        end else if (w_span - 1'b1 > smmce_pkg::RC_W'((2 ** smmce_pkg::ROW_W) - 1)) begin
            w_limit = smmce_pkg::RC_W'((2 ** smmce_pkg::ROW_W) - 1);
        end else begin
            w_limit = w_span - 1'b1;
        end
    end

    always_comb begin
        logic signed [smmce_pkg::V_W-1:0] v;
        logic [smmce_pkg::RC_W-1:0]       rc;
        for (int k = 0; k < smmce_pkg::NPEAK; k++) begin
            v = $signed({{(smmce_pkg::V_W - smmce_pkg::MID_W - smmce_pkg::SHIFT){1'b0}},
                         w_mid, {smmce_pkg::SHIFT{1'b0}}})
                - $signed({{(smmce_pkg::V_W - smmce_pkg::PROD_W){r_prod[k][smmce_pkg::PROD_W-1]}},
                           r_prod[k]});
            rc = v[smmce_pkg::SHIFT +: smmce_pkg::RC_W];
            if (v[smmce_pkg::V_W-1]) begin
                w_row[k] = '0;
            end else if (rc > w_limit) begin
                w_row[k] = w_limit[smmce_pkg::ROW_W-1:0];
            end else begin
                w_row[k] = rc[smmce_pkg::ROW_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_col1 <= i_head.column;
            for (int k = 0; k < smmce_pkg::NPEAK; k++) begin
                r_prod[k] <= smmce_pkg::PROD_W'($signed(i_head.peak[k])
                                                * $signed({1'b0, w_half}));
            end
            o_column           <= r_col1;
            o_left_top_row     <= w_row[smmce_pkg::PK_LHI];
            o_left_bottom_row  <= w_row[smmce_pkg::PK_LLO];
            o_right_top_row    <= w_row[smmce_pkg::PK_RHI];
            o_right_bottom_row <= w_row[smmce_pkg::PK_RLO];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_v1 <= !i_qstat.empty;
            r_ov <= r_v1;
        end
    end

endmodule

// ===== hdl/smmce_chk.sv =====
// Port-level checker for the stereo envelope unit, bound to the top level
`include "stereo_min_max_column_envelope_unit_macros.svh"

module smmce_chk (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   o_stall,
    input  logic                                   o_valid,
    input  logic                                   i_stall,
    input  logic [smmce_pkg::COL_W-1:0]            o_column,
    input  logic [smmce_pkg::ROW_W-1:0]            o_left_top_row,
    input  logic [smmce_pkg::ROW_W-1:0]            o_left_bottom_row,
    input  logic [smmce_pkg::ROW_W-1:0]            o_right_top_row,
    input  logic [smmce_pkg::ROW_W-1:0]            o_right_bottom_row
);

    logic                         r_seen;
    logic [smmce_pkg::COL_W-1:0]  r_last_col;
    logic [smmce_pkg::COL_W-1:0]  w_exp_col;

    assign w_exp_col = r_seen ? r_last_col + 1'b1 : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= 1'b0;
            r_last_col <= '0;
        end else if (o_valid && !i_stall) begin
            r_seen     <= 1'b1;
            r_last_col <= o_column;
        end
    end

    `SMMCE_ASSERT_NXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_column) && $stable(o_left_top_row))
    `SMMCE_ASSERT_IMP(a_left_order, o_valid, o_left_top_row <= o_left_bottom_row)
    `SMMCE_ASSERT_IMP(a_right_order, o_valid, o_right_top_row <= o_right_bottom_row)
    `SMMCE_ASSERT_IMP(a_col_seq, o_valid, o_column == w_exp_col)

endmodule

bind stereo_min_max_column_envelope_unit smmce_chk u_smmce_chk (.*);
